// ----- src/assert_macros.svh -----
// Assertion macros shared by the verification-side files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled while reset is high.
`define ASSERT_DIS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("jmdp assertion failed");

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("jmdp assertion failed");

`endif

// ----- src/jmdp_pkg.sv -----
// Types and constants for the jet/MET minimum delta-phi filter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package jmdp_pkg;

   localparam int PHI_W   = 10;
   localparam int ETA_W   = 10;
   localparam int PT_W    = 16;
   localparam int CNT_W   = 10;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 16;

   localparam logic [PHI_W-1:0] DPHI_NONE = 10'd1023;

   // Register indexes
   localparam logic [CSR_A_W-1:0] CSR_USE_PT      = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_MAX_JETS    = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_MIN_PT      = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_MAX_ABS_ETA = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_MIN_DPHI    = 3'd4;

   typedef struct packed {
      logic             use_pt;
      logic [CNT_W-1:0] max_jets;
      logic [PT_W-1:0]  min_pt;
      logic [ETA_W-1:0] max_abs_eta;
      logic [PHI_W-1:0] min_dphi;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      use_pt:      1'b1,
      max_jets:    10'd999,
      min_pt:      16'd0,
      max_abs_eta: 10'd1023,
      min_dphi:    10'd81
   };

   typedef struct packed {
      logic [PHI_W-1:0] smallest_dphi;
      logic [CNT_W-1:0] jets_counted;
   } state_type;

   localparam state_type STATE_RESET = '{
      smallest_dphi: DPHI_NONE,
      jets_counted:  '0
   };

   typedef struct packed {
      logic             jet_recorded;
      logic             event_end;
      logic             accept;
      logic [PHI_W-1:0] min_dphi_seen;
   } rsp_type;

endpackage
`default_nettype wire

// ----- src/jmdp_eval.sv -----
// Per-jet evaluation: cuts, wrapped |delta phi|, running minimum, event decision.
// Depends on jmdp_pkg. Purely combinational.
`timescale 1ns / 1ps
`default_nettype none
module jmdp_eval
   import jmdp_pkg::*;
(
   input  cfg_type                 cfg,
   input  state_type               cur,
   input  logic                    met_present,
   input  logic signed [PHI_W-1:0] met_phi,
   input  logic                    jet_present,
   input  logic [PT_W-1:0]         jet_pt,
   input  logic [PT_W-1:0]         jet_et,
   input  logic signed [ETA_W-1:0] jet_eta,
   input  logic signed [PHI_W-1:0] jet_phi,
   input  logic                    last_jet,
   output state_type               nxt,
   output rsp_type                 rsp
);

   logic [PT_W-1:0]  pt_sel;
   logic [ETA_W-1:0] eta_u;
   logic [ETA_W-1:0] abs_eta;
   logic [PHI_W-1:0] dphi_raw;
   logic [PHI_W-1:0] abs_dphi;
   logic             counted;
   logic             passed;
   logic [PHI_W-1:0] seen;

   always_comb begin
      pt_sel   = cfg.use_pt ? jet_pt : jet_et;
      eta_u    = jet_eta;
      // -512 negates to 10'h200, read as unsigned 512
      abs_eta  = eta_u[ETA_W-1] ? (~eta_u + 10'd1) : eta_u;
      dphi_raw = met_phi - jet_phi;
      abs_dphi = dphi_raw[PHI_W-1] ? (~dphi_raw + 10'd1) : dphi_raw;

      counted  = met_present && jet_present && (cur.jets_counted < cfg.max_jets);
      passed   = counted && (pt_sel > cfg.min_pt) && (abs_eta < cfg.max_abs_eta);

      seen     = (passed && (abs_dphi < cur.smallest_dphi)) ? abs_dphi : cur.smallest_dphi;

      rsp.jet_recorded  = passed;
      rsp.event_end     = last_jet;
      rsp.accept        = last_jet && ((seen == DPHI_NONE) || (seen > cfg.min_dphi));
      rsp.min_dphi_seen = seen;

      if (last_jet) begin
         nxt = STATE_RESET;
      end else begin
         nxt.smallest_dphi = seen;
         nxt.jets_counted  = counted ? (cur.jets_counted + 10'd1) : cur.jets_counted;
      end
   end

endmodule
`default_nettype wire

// ----- src/jet_met_min_delta_phi_filter.sv -----
// Jet/MET minimum delta-phi event filter, top level. Depends on jmdp_pkg, jmdp_eval.
// Results are registered in the output register, or in the skid entry while it is stalled.
// Throughput: one beat per cycle while the skid entry is empty; a skid register keeps
//   req_ready high for one extra beat while the output register is stalled.
// Reset (synchronous, active high): registers to defaults, event state cleared, no beats held.
`timescale 1ns / 1ps
`default_nettype none
module jet_met_min_delta_phi_filter
   import jmdp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // configuration writes
   input  logic                    csr_we,
   input  logic [CSR_A_W-1:0]      csr_index,
   input  logic [CSR_D_W-1:0]      csr_wdata,
   // request channel: one jet per beat
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_met_present,
   input  logic signed [PHI_W-1:0] req_met_phi,
   input  logic                    req_jet_present,
   input  logic [PT_W-1:0]         req_jet_pt,
   input  logic [PT_W-1:0]         req_jet_et,
   input  logic signed [ETA_W-1:0] req_jet_eta,
   input  logic signed [PHI_W-1:0] req_jet_phi,
   input  logic                    req_last_jet,
   // response channel: one result per request beat
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_jet_recorded,
   output logic                    rsp_event_end,
   output logic                    rsp_accept,
   output logic [PHI_W-1:0]        rsp_min_dphi_seen
);

   // Configuration registers
   cfg_type   cfg_ff, cfg_in;

   // Per-event running state: minimum |dphi| and jets examined so far.
   // Updated on the accepting edge so the next beat sees it immediately.
   state_type state_ff, state_in;

   // Output register plus one skid entry
   rsp_type   out_ff, out_in;
   logic      out_vld_ff, out_vld_in;
   rsp_type   skid_ff, skid_in;
   logic      skid_vld_ff, skid_vld_in;

   state_type eval_nxt;
   rsp_type   eval_rsp;
   logic      req_fire;
   logic      out_free;

   jmdp_eval u_eval (
      .cfg         (cfg_ff),
      .cur         (state_ff),
      .met_present (req_met_present),
      .met_phi     (req_met_phi),
      .jet_present (req_jet_present),
      .jet_pt      (req_jet_pt),
      .jet_et      (req_jet_et),
      .jet_eta     (req_jet_eta),
      .jet_phi     (req_jet_phi),
      .last_jet    (req_last_jet),
      .nxt         (eval_nxt),
      .rsp         (eval_rsp)
   );

   // Ready only depends on the skid entry being empty, so a beat is taken
   // even while the output register waits on rsp_ready.
   assign req_ready = !skid_vld_ff;
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !out_vld_ff || rsp_ready;

   // Register writes; unused indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_USE_PT:      cfg_in.use_pt      = csr_wdata[0];
            CSR_MAX_JETS:    cfg_in.max_jets    = csr_wdata[CNT_W-1:0];
            CSR_MIN_PT:      cfg_in.min_pt      = csr_wdata[PT_W-1:0];
            CSR_MAX_ABS_ETA: cfg_in.max_abs_eta = csr_wdata[ETA_W-1:0];
            CSR_MIN_DPHI:    cfg_in.min_dphi    = csr_wdata[PHI_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in = req_fire ? eval_nxt : state_ff;
   end

   // Output/skid steering. A beat can only arrive when skid is empty, so the
   // skid drains into the output register before new beats bypass it.
   always_comb begin
      out_in      = out_ff;
      out_vld_in  = out_vld_ff;
      skid_in     = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (out_free) begin
         if (skid_vld_ff) begin
            out_in      = skid_ff;
            out_vld_in  = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            out_in      = eval_rsp;
            out_vld_in  = req_fire;
         end
      end else if (req_fire) begin
         skid_in     = eval_rsp;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= CFG_RESET;
         state_ff    <= STATE_RESET;
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         state_ff    <= state_in;
         out_vld_ff  <= out_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_jet_recorded  = out_ff.jet_recorded;
   assign rsp_event_end     = out_ff.event_end;
   assign rsp_accept        = out_ff.accept;
   assign rsp_min_dphi_seen = out_ff.min_dphi_seen;

endmodule
`default_nettype wire

// ----- src/jmdp_checker.sv -----
// Port-level checks on the filter's response channel, bound to the top level.
// Depends on jmdp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module jmdp_checker
   import jmdp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_ready,
   input  wire logic             rsp_jet_recorded,
   input  wire logic             rsp_event_end,
   input  wire logic             rsp_accept,
   input  wire logic [PHI_W-1:0] rsp_min_dphi_seen
);

   // a stalled beat keeps its minimum
   `ASSERT_DIS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_min_dphi_seen))

   // a decision only appears on the closing beat
   `ASSERT_DIS(a_accept_at_end, clock, reset, rsp_valid && rsp_accept |-> rsp_event_end)

   // a recorded jet yields a real half-turn-bounded minimum
   `ASSERT_DIS(a_recorded_min, clock, reset, rsp_valid && rsp_jet_recorded |-> rsp_min_dphi_seen <= 10'd512)

   // nothing left over after reset
   `ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

bind jet_met_min_delta_phi_filter jmdp_checker u_jmdp_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_jet_recorded  (rsp_jet_recorded),
   .rsp_event_end     (rsp_event_end),
   .rsp_accept        (rsp_accept),
   .rsp_min_dphi_seen (rsp_min_dphi_seen)
);
`default_nettype wire

// ----- tb/sv/jet_met_min_delta_phi_filter_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for jet_met_min_delta_phi_filter: directed events, then random
// event streams under several register settings. Depends on jmdp_pkg and the block.
module jet_met_min_delta_phi_filter_tb;
   import jmdp_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;      // extra wait once every result is back
   localparam int LONG_HOLD     = 300;    // receiver back-pressure stretch
   localparam int PHASE_JETS    = 120;
   localparam int REPORT_MAX    = 10;

   // one request beat as the bench keeps it
   typedef struct {
      logic                    met_present;
      logic signed [PHI_W-1:0] met_phi;
      logic                    jet_present;
      logic [PT_W-1:0]         jet_pt;
      logic [PT_W-1:0]         jet_et;
      logic signed [ETA_W-1:0] jet_eta;
      logic signed [PHI_W-1:0] jet_phi;
      logic                    last_jet;
   } jet_beat_t;

   logic                    clock;
   logic                    reset;
   logic                    csr_we;
   logic [CSR_A_W-1:0]      csr_index;
   logic [CSR_D_W-1:0]      csr_wdata;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_met_present;
   logic signed [PHI_W-1:0] req_met_phi;
   logic                    req_jet_present;
   logic [PT_W-1:0]         req_jet_pt;
   logic [PT_W-1:0]         req_jet_et;
   logic signed [ETA_W-1:0] req_jet_eta;
   logic signed [PHI_W-1:0] req_jet_phi;
   logic                    req_last_jet;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_jet_recorded;
   logic                    rsp_event_end;
   logic                    rsp_accept;
   logic [PHI_W-1:0]        rsp_min_dphi_seen;

   jet_met_min_delta_phi_filter uut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_met_present   (req_met_present),
      .req_met_phi       (req_met_phi),
      .req_jet_present   (req_jet_present),
      .req_jet_pt        (req_jet_pt),
      .req_jet_et        (req_jet_et),
      .req_jet_eta       (req_jet_eta),
      .req_jet_phi       (req_jet_phi),
      .req_last_jet      (req_last_jet),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_jet_recorded  (rsp_jet_recorded),
      .rsp_event_end     (rsp_event_end),
      .rsp_accept        (rsp_accept),
      .rsp_min_dphi_seen (rsp_min_dphi_seen)
   );

   // Bench-side copy of the filter: register mirror plus per-event state.
   cfg_type          cut_regs;
   logic [PHI_W-1:0] closest_dphi;   // 1023 means no jet has passed this event
   logic [CNT_W-1:0] jets_examined;

   jet_beat_t   jets_to_send[$];    // filled by the stimulus process, drained by the driver
   rsp_type     verdicts_due[$];    // predicted results, oldest first
   int unsigned beats_in_flight;    // popped for sending, result not yet checked
   int unsigned mismatches;
   int unsigned cycle_count;
   bit          calm;               // no idling on either side while set
   int unsigned hold_requests;      // bumped by the stimulus process to ask for a long hold
   int unsigned holds_started;

   // driver state
   jet_beat_t   on_wire;
   int unsigned send_gap;

   // receiver state
   int unsigned stall_left;
   int unsigned hold_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result of one accepted jet; updates the event state as the block does.
   task automatic predict_verdict(input jet_beat_t j, output rsp_type r);
      logic [PT_W-1:0]         momentum;
      logic signed [PHI_W-1:0] dphi;
      int                      eta_mag;
      int                      dphi_mag;
      momentum = cut_regs.use_pt ? j.jet_pt : j.jet_et;
      eta_mag  = int'(j.jet_eta);
      if (eta_mag < 0) eta_mag = -eta_mag;
      // azimuth difference wraps to 10 bits, so -512 is the half turn
      dphi     = j.met_phi - j.jet_phi;
      dphi_mag = int'(dphi);
      if (dphi_mag < 0) dphi_mag = -dphi_mag;
      r.jet_recorded = 1'b0;
      if (j.met_present && j.jet_present && jets_examined < cut_regs.max_jets) begin
         if (momentum > cut_regs.min_pt && eta_mag < int'(cut_regs.max_abs_eta)) begin
            if (dphi_mag < int'(closest_dphi)) closest_dphi = PHI_W'(dphi_mag);
            r.jet_recorded = 1'b1;
         end
         jets_examined = jets_examined + CNT_W'(1);
      end
      r.event_end     = j.last_jet;
      r.min_dphi_seen = closest_dphi;
      r.accept        = j.last_jet &&
                        (closest_dphi == DPHI_NONE || closest_dphi > cut_regs.min_dphi);
      if (j.last_jet) begin
         closest_dphi  = DPHI_NONE;
         jets_examined = '0;
      end
   endtask

   // Register write; caller sits on a rising edge, returns on one.
   task automatic write_reg(input logic [CSR_A_W-1:0] idx, input int unsigned val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_D_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_USE_PT:      cut_regs.use_pt      = val[0];
         CSR_MAX_JETS:    cut_regs.max_jets    = val[CNT_W-1:0];
         CSR_MIN_PT:      cut_regs.min_pt      = val[PT_W-1:0];
         CSR_MAX_ABS_ETA: cut_regs.max_abs_eta = val[ETA_W-1:0];
         CSR_MIN_DPHI:    cut_regs.min_dphi    = val[PHI_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_cuts(input int unsigned use_pt, input int unsigned max_jets,
                           input int unsigned min_pt, input int unsigned max_eta,
                           input int unsigned min_dphi);
      write_reg(CSR_USE_PT, use_pt);
      write_reg(CSR_MAX_JETS, max_jets);
      write_reg(CSR_MIN_PT, min_pt);
      write_reg(CSR_MAX_ABS_ETA, max_eta);
      write_reg(CSR_MIN_DPHI, min_dphi);
   endtask

   task automatic add_jet(input int mp, input int mphi, input int jp, input int pt,
                          input int et, input int eta, input int phi, input int last);
      jet_beat_t b;
      b.met_present = mp[0];
      b.met_phi     = PHI_W'(mphi);
      b.jet_present = jp[0];
      b.jet_pt      = PT_W'(pt);
      b.jet_et      = PT_W'(et);
      b.jet_eta     = ETA_W'(eta);
      b.jet_phi     = PHI_W'(phi);
      b.last_jet    = last[0];
      jets_to_send.push_back(b);
   endtask

   // One event: mostly well-formed jets near the MET direction, some noise beats,
   // now and then an empty event.
   task automatic queue_random_event(inout int count);
      jet_beat_t        b;
      int               n_jets;
      logic [PHI_W-1:0] met_dir;
      logic             met_on;
      n_jets  = $urandom_range(1, 10);
      met_dir = PHI_W'($urandom);
      met_on  = ($urandom_range(0, 9) != 0);
      if ($urandom_range(0, 14) == 0) begin
         b.met_present = 1'($urandom);
         b.met_phi     = met_dir;
         b.jet_present = 1'b0;
         b.jet_pt      = PT_W'($urandom);
         b.jet_et      = PT_W'($urandom);
         b.jet_eta     = ETA_W'($urandom);
         b.jet_phi     = PHI_W'($urandom);
         b.last_jet    = 1'b1;
         jets_to_send.push_back(b);
         count++;
      end else begin
         for (int k = 0; k < n_jets; k++) begin
            b.met_present = met_on;
            b.met_phi     = met_dir;
            b.jet_present = 1'b1;
            b.jet_pt      = ($urandom_range(0, 3) == 0) ? PT_W'($urandom)
                                                        : PT_W'($urandom_range(0, 4000));
            b.jet_et      = ($urandom_range(0, 3) == 0) ? PT_W'($urandom)
                                                        : PT_W'($urandom_range(0, 4000));
            b.jet_eta     = ETA_W'($urandom);
            case ($urandom_range(0, 3))
               0, 1:    b.jet_phi = PHI_W'(int'(met_dir) + int'($urandom_range(0, 200))
                                           - 100);
               2:       b.jet_phi = PHI_W'(int'(met_dir) + 512
                                           + int'($urandom_range(0, 20)) - 10);
               default: b.jet_phi = PHI_W'($urandom);
            endcase
            if ($urandom_range(0, 9) == 0) begin
               // broken beat: MET or jet flags and MET direction scrambled mid-event
               b.met_present = 1'($urandom);
               b.met_phi     = PHI_W'($urandom);
               b.jet_present = 1'($urandom);
            end
            b.last_jet = (k == n_jets - 1);
            jets_to_send.push_back(b);
            count++;
         end
      end
   endtask

   // Sender stops here until every result is back, then lets the pipe settle.
   task automatic wait_idle();
      while (!(jets_to_send.size() == 0 && beats_in_flight == 0)) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Request driver: one beat at a time from jets_to_send, random gap bursts.
   always @(posedge clock) begin
      rsp_type verdict;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_verdict(on_wire, verdict);
            verdicts_due.push_back(verdict);
         end
         if (req_valid && !req_ready) begin
            // beat not taken yet: hold valid and payload
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (jets_to_send.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 10);   // idle burst, length drawn into send_gap
            req_valid <= 1'b0;
         end else begin
            on_wire = jets_to_send.pop_front();
            beats_in_flight++;
            req_met_present <= on_wire.met_present;
            req_met_phi     <= on_wire.met_phi;
            req_jet_present <= on_wire.jet_present;
            req_jet_pt      <= on_wire.jet_pt;
            req_jet_et      <= on_wire.jet_et;
            req_jet_eta     <= on_wire.jet_eta;
            req_jet_phi     <= on_wire.jet_phi;
            req_last_jet    <= on_wire.last_jet;
            req_valid       <= 1'b1;
         end
      end
   end

   // Result monitor and receiver: checks each rsp beat, drives rsp_ready with
   // random stalls and the long hold-off when asked.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: unexpected beat: rec %0b end %0b acc %0b min %0d",
                           $time, rsp_jet_recorded, rsp_event_end, rsp_accept,
                           rsp_min_dphi_seen);
            end else begin
               want = verdicts_due.pop_front();
               beats_in_flight--;
               if (rsp_jet_recorded !== want.jet_recorded || rsp_event_end !== want.event_end ||
                   rsp_accept !== want.accept || rsp_min_dphi_seen !== want.min_dphi_seen) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display({"%0t: mismatch (exp/act) rec %0b/%0b end %0b/%0b",
                               " acc %0b/%0b min %0d/%0d"},
                              $time, want.jet_recorded, rsp_jet_recorded,
                              want.event_end, rsp_event_end, want.accept, rsp_accept,
                              want.min_dphi_seen, rsp_min_dphi_seen);
               end
            end
         end
         if (holds_started != hold_requests) begin
            holds_started = hold_requests;
            hold_left     = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int n;
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_met_present = 1'b0;
      req_met_phi     = '0;
      req_jet_present = 1'b0;
      req_jet_pt      = '0;
      req_jet_et      = '0;
      req_jet_eta     = '0;
      req_jet_phi     = '0;
      req_last_jet    = 1'b0;
      rsp_ready       = 1'b0;
      cut_regs        = CFG_RESET;
      closest_dphi    = DPHI_NONE;
      jets_examined   = '0;
      beats_in_flight = 0;
      mismatches      = 0;
      cycle_count     = 0;
      calm            = 1'b0;
      hold_requests   = 0;
      holds_started   = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset settings: empty event, event without MET, strict pt cut
      // at zero, half-turn and wrap-around azimuths, decision right at min_dphi.
      add_jet(1, 0, 0, 0, 0, 0, 0, 1);
      add_jet(0, 100, 1, 500, 500, 0, 100, 1);
      add_jet(1, -512, 1, 0, 65535, 0, 0, 0);
      add_jet(1, -512, 1, 65535, 0, -512, 0, 0);
      add_jet(1, -512, 1, 40, 0, 511, 511, 1);
      add_jet(1, 511, 1, 7, 0, 0, -512, 1);
      add_jet(1, 0, 1, 9, 9, 3, 81, 1);
      add_jet(1, 100, 1, 9, 9, -3, 18, 1);
      add_jet(1, 511, 1, 65535, 65535, 511, 511, 1);
      add_jet(1, -512, 1, 1, 0, -512, -512, 1);
      wait_idle();

      // Directed, et cut, two jets per event, tight eta, min_dphi at a half turn:
      // jets past the count, values right on each cut, jetless beat mid-event.
      set_cuts(0, 2, 100, 200, 512);
      add_jet(1, 0, 1, 0, 101, 199, 300, 0);
      add_jet(1, 0, 1, 0, 101, -199, 10, 0);
      add_jet(1, 0, 1, 0, 5000, 0, 5, 0);
      add_jet(1, 0, 1, 0, 5000, 0, 0, 1);
      add_jet(1, 0, 1, 65535, 100, 0, 0, 0);
      add_jet(1, 0, 1, 0, 101, 200, 0, 0);
      add_jet(1, 0, 1, 0, 101, -200, 0, 1);
      add_jet(1, 0, 0, 0, 999, 0, 0, 0);
      add_jet(1, -512, 1, 0, 1000, 0, 0, 1);
      wait_idle();

      // Random phases, one register setting each; phases 4 and 7 run without idling.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0:       set_cuts(1, 1023, 0, 1023, 0);
            1:       set_cuts(0, 0, 0, 0, 0);
            2:       set_cuts(1, 1023, 65535, 1023, 1023);
            default: set_cuts($urandom_range(0, 1), $urandom_range(1, 6),
                              $urandom_range(0, 2000), $urandom_range(100, 1023),
                              $urandom_range(0, 520));
         endcase
         calm = (ph == 4 || ph == 7);
         n = 0;
         while (n < PHASE_JETS) queue_random_event(n);
         // long receiver hold while the driver keeps offering: req_ready must drop
         if (ph == 3) hold_requests <= hold_requests + 1;
         wait_idle();
      end

      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
